// ===== hdl/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
package isort_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int DEPTH_DEFAULT = 64;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         set_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         run_end;
      logic                         overflow;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;   // input word taken this cycle
      logic emit;     // output word taken this cycle
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_word;  // the word at the head of the store is the final one
   } status_type;

endpackage

// ===== hdl/insertion_sorter.sv =====
// Top level of the stable ascending insertion sorter.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | value, set_end
//   rsp     | out       | rsp_valid/rsp_stall  | sorted_value, run_end, overflow
//
// An input word is inserted when it is taken: every held cell compares with it at once
// and the greater ones move up one place, so input words may arrive back to back.
// A word with set_end closes the set: from the next cycle the set leaves at one word
// per cycle while rsp_stall is low, from the head of the cell row, and req_stall stays
// high until the final word (run_end) is taken. Reset is synchronous and empties the
// store; no clearing pass is needed. While rsp_stall is high the head word and its
// flags hold.
module insertion_sorter #(
   parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  isort_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output isort_pkg::rsp_type  rsp_data
);
   import isort_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: gates the input during emission and paces the output
   isort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_set_end (req_data.set_end),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: sorted cell row, held count and drop flag
   isort_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/isort_ctrl.sv =====
// Controller for the insertion sorter: fill and emit phases.
module isort_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_set_end,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  isort_pkg::status_type  status,
   output isort_pkg::cmd_type     cmd
);
   import isort_pkg::*;

   typedef enum logic {
      FILL,
      EMIT
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   assign cmd.accept = req_valid && !req_stall_ff;
   assign cmd.emit   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = req_stall_ff;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FILL;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            FILL: begin
               if (cmd.accept && req_set_end) begin
                  state_ff     <= EMIT;
                  req_stall_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            EMIT: begin
               if (cmd.emit && status.last_word) begin
                  state_ff     <= FILL;
                  req_stall_ff <= 1'b0;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= FILL;
               req_stall_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   // Input and output phases never overlap
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == req_stall_ff)
      else $error("input open while results pending");

   // A set end starts emission on the next cycle
   a_set_end_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && req_set_end |=> rsp_valid_ff)
      else $error("set end did not start emission");

   // Emission continues until the final word goes out
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(cmd.emit && status.last_word) |=> rsp_valid_ff)
      else $error("emission stopped early");

endmodule

// ===== hdl/isort_dpath.sv =====
// Datapath for the insertion sorter: sorted cell row, count and drop flag.
module isort_dpath #(
   parameter int DEPTH = isort_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  isort_pkg::cmd_type     cmd,
   input  isort_pkg::req_type     req_data,
   output isort_pkg::status_type  status,
   output isort_pkg::rsp_type     rsp_data
);
   import isort_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic signed [DATA_WIDTH-1:0] store_in [DEPTH];
   logic [DEPTH-1:0]             gt;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         dropped_ff;
   logic                         dropped_in;
   logic                         full;
   logic                         insert;

   assign full   = (count_ff == CW'(DEPTH));
   assign insert = cmd.accept && !full;

   // Each held cell compares against the new word; strict compare keeps ties stable
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CW'(i) < count_ff) && (store_ff[i] > req_data.value);
      end
   end

   // Cells above the slot take their lower neighbor, the slot takes the new word
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || CW'(i) == count_ff) begin
            store_in[i] = req_data.value;
         end else begin
            store_in[i] = store_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
      end else if (cmd.emit) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            store_ff[i] <= store_ff[i + 1];
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.accept) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else if (cmd.emit) begin
         count_in = count_ff - CW'(1);
         if (status.last_word) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.last_word      = (count_ff == CW'(1));
   assign rsp_data.sorted_value = store_ff[0];
   assign rsp_data.run_end      = status.last_word;
   assign rsp_data.overflow     = dropped_ff;

   // Never emit from an empty store
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> count_ff != '0)
      else $error("emit with empty store");

   // The final word leaves the store empty and the drop flag clear
   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.last_word |=> count_ff == '0 && !dropped_ff)
      else $error("set end did not clear state");

   // Head of the store stays in ascending order
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(2) |-> store_ff[0] <= store_ff[1])
      else $error("store head out of order");

endmodule
